// ----- design/ostp_pkg.sv -----
package ostp_pkg;

   // Field widths of the transactions and the slot counters.
   localparam int DUR_W  = 40;
   localparam int REM_W  = 50;
   localparam int TPU_W  = 10;
   localparam int MODE_W = 2;
   localparam int ID_W   = 2;
   localparam int MASK_W = 2;

   // Timer clock ticks per microsecond after reset.
   localparam logic [TPU_W-1:0] TPU_RESET = 10'd100;

   // Command codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

   // Request transaction.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DUR_W-1:0]  duration_us;
      logic [ID_W-1:0]   slot_id;
   } req_type;

   // Response transaction.
   typedef struct packed {
      logic [ID_W-1:0]   alloc_id;
      logic [MASK_W-1:0] fired_mask;
   } rsp_type;

   // Control from the pool towards one slot.
   typedef struct packed {
      logic load;
      logic drop;
      logic tick;
   } slot_cmd_type;

   // Status from one slot back to the pool.
   typedef struct packed {
      logic busy;
      logic fire;
   } slot_stat_type;

endpackage

// ----- design/ostp_slot.sv -----
module ostp_slot import ostp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  slot_cmd_type     cmd,
   input  logic [REM_W-1:0] load_value,
   output slot_stat_type    stat
);

   logic             busy_ff;
   logic             busy_in;
   logic [REM_W-1:0] remaining_ff;
   logic [REM_W-1:0] remaining_in;
   logic             expiring;

   // A busy slot expires on a tick when its count is zero or one.
   assign expiring = busy_ff && (remaining_ff <= REM_W'(1));

   // Next state of the slot: load wins, then release, then the tick.
   always_comb begin
      busy_in      = busy_ff;
      remaining_in = remaining_ff;
      if (cmd.load) begin
         busy_in      = 1'b1;
         remaining_in = load_value;
      end else if (cmd.drop) begin
         busy_in      = 1'b0;
         remaining_in = '0;
      end else if (cmd.tick && busy_ff) begin
         if (expiring) begin
            busy_in      = 1'b0;
            remaining_in = '0;
         end else begin
            remaining_in = remaining_ff - REM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // The count is only looked at while the slot is busy.
   always_ff @(posedge clock) begin
      remaining_ff <= remaining_in;
   end

   assign stat.busy = busy_ff;
   assign stat.fire = cmd.tick && expiring;

endmodule

// ----- design/ostp_pick.sv -----
module ostp_pick import ostp_pkg::*; #(
   parameter int SLOTS = 2,
   parameter int IDX_W = 1
) (
   input  logic [SLOTS-1:0] free_vec,
   output logic             found,
   output logic [IDX_W-1:0] index
);

   // Priority pick of the lowest-numbered free slot.
   always_comb begin
      found = 1'b0;
      index = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (free_vec[s]) begin
            found = 1'b1;
            index = IDX_W'(s);
         end
      end
   end

endmodule

// ----- design/one_shot_timer_pool_unit.sv -----
// Pool of SLOTS one-shot timer slots.
// Request channel: a transaction is taken at a rising edge with start high
// and busy low. busy is always low, so one command is taken every cycle.
// The mode field selects allocate, free, tick or a no-op; duration_us
// is used by allocate and slot_id by free.
// Response channel: every command gives exactly one response, shown on
// rsp_payload for one cycle while rsp_valid is high. The receiver cannot
// stall it and must take it in that cycle.
// A taken command is held in the command register and executed into
// the slots and the response register. Throughput is one command per
// cycle, set by the single pass through the slot logic and the duration
// multiplier between the command register and the slots.
// Configuration: csr_wdata writes ticks_per_us whenever csr_valid is high;
// csr_ready is always high. Write it only while no command is in flight.
// Reset clears every slot to free, empties the pipeline and sets
// ticks_per_us to 100.
module one_shot_timer_pool_unit import ostp_pkg::*; #(
   parameter int SLOTS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TPU_W-1:0] csr_wdata
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [TPU_W-1:0] tpu_ff;
   logic             stage_valid_ff;
   req_type          stage_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic [REM_W-1:0]  load_value;
   logic              do_alloc;
   logic              do_free;
   logic              do_tick;
   logic              pick_found;
   logic [IDX_W-1:0]  pick_index;
   logic [SLOTS-1:0]  free_vec;
   logic [SLOTS-1:0]  fire_vec;
   logic [SLOTS+1:0]  fire_wide;
   slot_cmd_type      slot_cmd  [SLOTS];
   slot_stat_type     slot_stat [SLOTS];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff <= TPU_RESET;
      end else if (csr_valid && csr_ready) begin
         tpu_ff <= csr_wdata;
      end
   end

   // Command register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         stage_ff <= req_payload;
      end
   end

   // Decode of the registered command.
   assign do_alloc = stage_valid_ff && (stage_ff.mode == MODE_ALLOC)
                     && (stage_ff.duration_us != '0);
   assign do_free  = stage_valid_ff && (stage_ff.mode == MODE_FREE);
   assign do_tick  = stage_valid_ff && (stage_ff.mode == MODE_TICK);

   // Duration in timer ticks, truncated to the counter width.
   assign load_value = REM_W'(stage_ff.duration_us) * REM_W'(tpu_ff);

   ostp_pick #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_pick (
      .free_vec (free_vec),
      .found    (pick_found),
      .index    (pick_index)
   );

   // One counter per slot.
   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      assign slot_cmd[s].load = do_alloc && pick_found && (pick_index == IDX_W'(s));
      assign slot_cmd[s].drop = do_free
                                && ({30'd0, stage_ff.slot_id} == 32'(s + 1));
      assign slot_cmd[s].tick = do_tick;

      ostp_slot u_slot (
         .clock      (clock),
         .reset      (reset),
         .cmd        (slot_cmd[s]),
         .load_value (load_value),
         .stat       (slot_stat[s])
      );

      assign free_vec[s] = !slot_stat[s].busy;
      assign fire_vec[s] = slot_stat[s].fire;
   end

   // Response of the command, narrowed to the field widths.
   assign fire_wide = {2'b00, fire_vec};

   always_comb begin
      rsp_in.alloc_id   = '0;
      rsp_in.fired_mask = fire_wide[MASK_W-1:0];
      if (do_alloc && pick_found) begin
         rsp_in.alloc_id = ID_W'({1'b0, pick_index} + (IDX_W + 1)'(1));
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A response only follows a command that was executed in the previous cycle.
   a_rsp_follows_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(stage_valid_ff))
      else $error("response without a command");

   // Fired bits only appear on a tick.
   a_fire_on_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.fired_mask != '0)) |-> $past(do_tick))
      else $error("fired mask outside a tick");

   // A slot number is only returned by an allocate.
   a_id_on_alloc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.alloc_id != '0)) |-> $past(do_alloc))
      else $error("slot number outside an allocate");

   // A successful allocate leaves the picked slot busy.
   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      (do_alloc && pick_found) |=> !free_vec[$past(pick_index)])
      else $error("allocate did not take a slot");

endmodule
